// ===== sv/u2c_pkg.sv =====
// Shared types, constants and helper functions for the UTF-8 to C literal escaper.
// Used by the top level and by its port checker; depends on nothing else.
package u2c_pkg;

  // Code point limits of the UTF-8 decoder and the text generator.
  localparam logic [20:0] CP_REPLACEMENT = 21'h00FFFD;
  localparam logic [20:0] CP_MAX         = 21'h10FFFF;
  localparam logic [20:0] CP_SURR_LO     = 21'h00D800;
  localparam logic [20:0] CP_SURR_HI     = 21'h00DFFF;
  localparam logic [20:0] CP_MIN_TWO     = 21'h000080;
  localparam logic [20:0] CP_MIN_THREE   = 21'h000800;
  localparam logic [20:0] CP_MIN_FOUR    = 21'h010000;
  localparam logic [20:0] CP_BMP_MAX     = 21'h00FFFF;
  localparam logic [20:0] CP_PRINT_LO    = 21'h000020;
  localparam logic [20:0] CP_PRINT_HI    = 21'h00007E;

  // ASCII characters of the escaped text.
  localparam logic [6:0] CH_BSLASH  = 7'h5C;
  localparam logic [6:0] CH_QUOTE   = 7'h22;
  localparam logic [6:0] CH_LOW_U   = 7'h75;
  localparam logic [6:0] CH_UP_U    = 7'h55;
  localparam logic [6:0] CH_ZERO    = 7'h30;
  localparam logic [6:0] CH_UP_A    = 7'h41;
  localparam logic [6:0] CH_LOW_R   = 7'h72;
  localparam logic [6:0] CH_LOW_T   = 7'h74;
  localparam logic [6:0] CH_LOW_A   = 7'h61;
  localparam logic [6:0] CH_LOW_B   = 7'h62;
  localparam logic [6:0] CH_LOW_F   = 7'h66;
  localparam logic [6:0] CH_LOW_V   = 7'h76;
  localparam logic [6:0] CH_LOW_N   = 7'h6E;
  localparam logic [6:0] CH_PRINT_LO = 7'h20;
  localparam logic [6:0] CH_PRINT_HI = 7'h7E;

  // Work handed from the decoder to the text generator for one input byte.
  typedef struct packed {
    logic [2:0]  nf;      // replacement characters still to emit
    logic        has_cp;  // a decoded code point follows them
    logic [20:0] cp;
    logic        fin;     // byte closed the value
  } cmd_t;

  // Continuation bytes a lead byte announces; zero for ASCII and bad leads.
  function automatic logic [1:0] lead_need(input logic [7:0] b);
    logic [1:0] n;
    n = 2'd0;
    if (b[7:5] == 3'b110) n = 2'd1;
    else if (b[7:4] == 4'b1110) n = 2'd2;
    else if (b[7:3] == 5'b11110) n = 2'd3;
    return n;
  endfunction

  // Returns {hit, letter} for code points with a two-character escape.
  function automatic logic [7:0] esc_letter(input logic [20:0] cp);
    logic [7:0] r;
    r = 8'd0;
    if (cp[20:7] == 14'd0) begin
      unique case (cp[6:0])
        7'h5C:   r = {1'b1, CH_BSLASH};
        7'h22:   r = {1'b1, CH_QUOTE};
        7'h0D:   r = {1'b1, CH_LOW_R};
        7'h09:   r = {1'b1, CH_LOW_T};
        7'h07:   r = {1'b1, CH_LOW_A};
        7'h08:   r = {1'b1, CH_LOW_B};
        7'h0C:   r = {1'b1, CH_LOW_F};
        7'h0B:   r = {1'b1, CH_LOW_V};
        7'h0A:   r = {1'b1, CH_LOW_N};
        default: r = 8'd0;
      endcase
    end
    return r;
  endfunction

  function automatic logic [6:0] hex_char(input logic [3:0] d);
    logic [6:0] c;
    if (d < 4'd10) c = CH_ZERO + {3'd0, d};
    else c = CH_UP_A + {3'd0, d - 4'd10};
    return c;
  endfunction

endpackage

// ===== sv/utf8_to_c_literal_escaper.sv =====
// UTF-8 to C string-literal escaper: decodes one UTF-8 byte per input word and
// emits the escaped ASCII text one character per output word. A plain printable
// byte sustains one word per cycle while out_ready_i holds, and passes through
// the command register and then the output register. A byte whose text is longer
// holds off the next input word until its last character is generated (a short
// escape is 2 characters, \uXXXX 6, \UXXXXXXXX 10, and up to 24 when pending
// bytes are replaced by U+FFFD), since the command register holds one byte's work.
// Bytes that only extend a pending sequence produce no output.
// Depends on u2c_pkg.
module utf8_to_c_literal_escaper (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_final_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [6:0] out_char_o,
  output logic       run_end_o,
  output logic       value_end_o
);
  import u2c_pkg::*;

  // Decoder state
  logic [7:0] lead_q, lead_d;
  logic [1:0] need_q, need_d;
  logic [1:0] held_q, held_d;
  logic [7:0] cont_q [2];
  logic       cont_we;

  // Command register and generator position
  logic       cmd_valid_q, cmd_valid_d;
  cmd_t       cmd_q, cmd_d, dec;
  logic [3:0] pos_q, pos_d;

  // Output register
  logic       out_valid_q;
  logic [6:0] out_char_q;
  logic       run_end_q, value_end_q;

  logic        accept, enq, out_adv, gen, cp_last, cmd_last, cmd_retire;
  logic [20:0] cur_cp, dec_cp;
  logic [7:0]  esc;
  logic [3:0]  len, hex_idx;
  logic [6:0]  ch;
  logic [31:0] cp_pad;
  logic        wide, seq_ok, lead_take;
  logic [2:0]  held_n;

  // Decoder: next state and the command for the accepted byte.
  always_comb begin
    lead_d    = lead_q;
    need_d    = need_q;
    held_d    = held_q;
    cont_we   = 1'b0;
    lead_take = 1'b0;
    seq_ok    = 1'b0;
    dec_cp    = 21'd0;
    held_n    = {1'b0, held_q} + 3'd1;
    dec       = '0;
    dec.fin   = in_final_i;

    unique case (need_q)
      2'd1: dec_cp = {10'd0, lead_q[4:0], in_byte_i[5:0]};
      2'd2: dec_cp = {5'd0, lead_q[3:0], cont_q[0][5:0], in_byte_i[5:0]};
      default: dec_cp = {lead_q[2:0], cont_q[0][5:0], cont_q[1][5:0], in_byte_i[5:0]};
    endcase
    unique case (need_q)
      2'd1: seq_ok = dec_cp >= CP_MIN_TWO;
      2'd2: seq_ok = dec_cp >= CP_MIN_THREE &&
                     !(dec_cp >= CP_SURR_LO && dec_cp <= CP_SURR_HI);
      default: seq_ok = dec_cp >= CP_MIN_FOUR && dec_cp <= CP_MAX;
    endcase

    if (need_q == 2'd0) begin
      lead_take = 1'b1;
    end else if (in_byte_i[7:6] == 2'b10) begin
      cont_we = !held_q[1];
      if (held_n >= {1'b0, need_q}) begin
        if (seq_ok) begin
          dec.has_cp = 1'b1;
          dec.cp     = dec_cp;
        end else begin
          dec.nf = held_n + 3'd1;
        end
        need_d = 2'd0;
        held_d = 2'd0;
        lead_d = 8'd0;
      end else if (in_final_i) begin
        dec.nf = held_n + 3'd1;
        need_d = 2'd0;
        held_d = 2'd0;
        lead_d = 8'd0;
      end else begin
        held_d = held_n[1:0];
      end
    end else begin
      // Broken sequence: lead and held bytes are replaced, new byte is a lead.
      dec.nf    = held_n;
      need_d    = 2'd0;
      held_d    = 2'd0;
      lead_d    = 8'd0;
      lead_take = 1'b1;
    end

    if (lead_take) begin
      if (!in_byte_i[7]) begin
        dec.has_cp = 1'b1;
        dec.cp     = {13'd0, in_byte_i};
      end else if (lead_need(in_byte_i) == 2'd0 || in_final_i) begin
        dec.nf = dec.nf + 3'd1;
      end else begin
        lead_d = in_byte_i;
        need_d = lead_need(in_byte_i);
        held_d = 2'd0;
      end
    end
  end

  // Text generator: character at pos_q of the current code point.
  always_comb begin
    cur_cp  = (cmd_q.nf != 3'd0) ? CP_REPLACEMENT : cmd_q.cp;
    cp_pad  = {11'd0, cur_cp};
    esc     = esc_letter(cur_cp);
    wide    = cur_cp > CP_BMP_MAX;
    hex_idx = wide ? (4'd9 - pos_q) : (4'd5 - pos_q);
    if (esc[7]) begin
      len = 4'd2;
      ch  = (pos_q == 4'd0) ? CH_BSLASH : esc[6:0];
    end else if (cur_cp >= CP_PRINT_LO && cur_cp <= CP_PRINT_HI) begin
      len = 4'd1;
      ch  = cur_cp[6:0];
    end else begin
      len = wide ? 4'd10 : 4'd6;
      if (pos_q == 4'd0) ch = CH_BSLASH;
      else if (pos_q == 4'd1) ch = wide ? CH_UP_U : CH_LOW_U;
      else ch = hex_char(cp_pad[{hex_idx[2:0], 2'b00} +: 4]);
    end
  end

  assign cp_last    = pos_q == (len - 4'd1);
  assign cmd_last   = cp_last &&
                      (cmd_q.nf == 3'd0 || (cmd_q.nf == 3'd1 && !cmd_q.has_cp));
  assign out_adv    = !out_valid_q || out_ready_i;
  assign gen        = cmd_valid_q && out_adv;
  assign cmd_retire = gen && cmd_last;
  assign in_ready_o = !cmd_valid_q || cmd_retire;
  assign accept     = in_valid_i && in_ready_o;
  assign enq        = accept && (dec.nf != 3'd0 || dec.has_cp);

  always_comb begin
    cmd_valid_d = cmd_valid_q;
    cmd_d       = cmd_q;
    pos_d       = pos_q;
    if (!cmd_valid_q || cmd_retire) begin
      cmd_valid_d = enq;
      cmd_d       = dec;
      pos_d       = 4'd0;
    end else if (gen) begin
      if (cp_last) begin
        pos_d    = 4'd0;
        cmd_d.nf = cmd_q.nf - 3'd1;
      end else begin
        pos_d = pos_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_q      <= 8'd0;
      need_q      <= 2'd0;
      held_q      <= 2'd0;
      cmd_valid_q <= 1'b0;
      pos_q       <= 4'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        lead_q <= lead_d;
        need_q <= need_d;
        held_q <= held_d;
      end
      cmd_valid_q <= cmd_valid_d;
      pos_q       <= pos_d;
      if (out_adv) out_valid_q <= cmd_valid_q;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (accept && cont_we) cont_q[held_q[0]] <= in_byte_i;
    cmd_q <= cmd_d;
    if (gen) begin
      out_char_q  <= ch;
      run_end_q   <= cmd_last;
      value_end_q <= cmd_last && cmd_q.fin;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign run_end_o   = run_end_q;
  assign value_end_o = value_end_q;

endmodule

// ===== sv/u2c_checker.sv =====
// Port-level checker for the UTF-8 to C literal escaper, bound to the top level.
// Depends on u2c_pkg for the printable character limits.
module u2c_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [7:0] in_byte_i,
  input logic       in_final_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [6:0] out_char_o,
  input logic       run_end_o,
  input logic       value_end_o
);
  import u2c_pkg::*;

  // Finals accepted whose closing word has not yet been delivered.
  logic [3:0] fin_cnt_q;
  logic       fin_in, fin_out;

  assign fin_in  = in_valid_i && in_ready_o && in_final_i;
  assign fin_out = out_valid_o && out_ready_i && value_end_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_cnt_q <= 4'd0;
    end else begin
      fin_cnt_q <= fin_cnt_q + {3'd0, fin_in} - {3'd0, fin_out};
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_char_o) &&
      $stable(run_end_o) && $stable(value_end_o))
    else $error("output word changed while stalled");

  a_value_end_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && value_end_o |-> run_end_o)
    else $error("value end without run end");

  a_printable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_char_o >= CH_PRINT_LO && out_char_o <= CH_PRINT_HI)
    else $error("non-printable character emitted");

  a_value_end_owed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_out |-> fin_cnt_q != 4'd0)
    else $error("value end without a final input byte");

endmodule

bind utf8_to_c_literal_escaper u2c_checker u_u2c_checker (.*);
